FILE: sv/snm_pkg.sv
`default_nettype none
package snm_pkg;

    localparam int DEF_MAX_POINTS  = 4096;
    localparam int DEF_MAX_NOTCHES = 8;

    localparam int FREQ_W = 40;
    localparam int BW_W   = 39;
    localparam int PTS_W  = 13;
    localparam int FRAC_W = 16;
    localparam int IDX_W  = 12;
    localparam int SMP_W  = 32;
    localparam int REM_W  = 13;
    localparam int STAT_W = 2;

    // quotient bits of the shared divider; covers edge bins and the fraction step
    localparam int DIV_STEPS = 18;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam int IN_DATA_W  = 176;
    localparam int OUT_DATA_W = 96;
    localparam int OUT_USER_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;

    typedef enum logic [1:0] {
        ACT_BEGIN = 2'd0,
        ACT_NOTCH = 2'd1,
        ACT_BIN   = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_ILLEGAL = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    localparam logic [CFG_IDX_W-1:0] REG_SIDEBAND  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHAN_FREQ = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BANDWIDTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POINTS    = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ELOAD,
        S_EDIV,
        S_ESAVE,
        S_COUNT,
        S_NLOAD,
        S_NDIV,
        S_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic mul;
        logic second;
        logic div_load_edge;
        logic div_load_nib;
        logic div_step;
        logic save_edge;
        logic count;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic needs_calc;
    } dp_stat_t;

endpackage
`default_nettype wire

FILE: sv/snm_div.sv
`default_nettype none
module snm_div
    import snm_pkg::*;
#(
    parameter int WW = 64,
    parameter int QW = DIV_STEPS
) (
    input  wire logic          aclk,
    input  wire logic          load,
    input  wire logic [WW-1:0] num,
    input  wire logic [WW-1:0] den,
    input  wire logic          step,
    output logic      [QW-1:0] quo
);

    logic [WW-1:0] rem_reg, rem_next;
    logic [WW-1:0] dsh_reg, dsh_next;
    logic [QW-1:0] quo_reg, quo_next;

    always_comb begin
        rem_next = rem_reg;
        dsh_next = dsh_reg;
        quo_next = quo_reg;
        if (load) begin
            rem_next = num;
            dsh_next = den << (QW - 1);
            quo_next = '0;
        end else if (step) begin
            if (rem_reg >= dsh_reg) begin
                rem_next = rem_reg - dsh_reg;
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end else begin
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
            dsh_next = dsh_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign quo = quo_reg;

endmodule
`default_nettype wire

FILE: sv/snm_dp.sv
`default_nettype none
module snm_dp
    import snm_pkg::*;
#(
    parameter int MAX_POINTS  = DEF_MAX_POINTS,
    parameter int MAX_NOTCHES = DEF_MAX_NOTCHES
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic [1:0]            s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [OUT_DATA_W-1:0] m_tdata,
    output logic      [OUT_USER_W-1:0] m_tuser,
    input  wire dp_cmd_t               cmd,
    output dp_stat_t                   stat
);

    localparam int PW  = $clog2(MAX_POINTS + 1);
    localparam int SW  = PW + 2;
    localparam int CW  = (PW > IDX_W) ? PW : IDX_W;
    localparam int NCW = $clog2(MAX_NOTCHES + 1);
    localparam int IW  = (MAX_NOTCHES > 1) ? $clog2(MAX_NOTCHES) : 1;
    localparam int XW  = BW_W;
    localparam int WA  = XW + PW + 2;
    localparam int WB  = BW_W + 3 + DIV_STEPS - 1;
    localparam int WW  = (WA > WB) ? WA : WB;

    localparam logic [1:0] CLS_IN  = 2'd0;
    localparam logic [1:0] CLS_NEG = 2'd1;
    localparam logic [1:0] CLS_HI  = 2'd2;

    // configuration
    logic                     sideband_reg;
    logic signed [FREQ_W-1:0] chan_reg;
    logic        [BW_W-1:0]   bw_reg;
    logic        [PTS_W-1:0]  points_reg;

    // item fields
    action_t                  act;
    logic signed [FREQ_W-1:0] in_lo, in_hi;
    logic        [FRAC_W-1:0] in_frac;
    logic        [IDX_W-1:0]  in_idx;
    logic        [SMP_W-1:0]  in_re, in_im;

    // state
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [NCW-1:0]    stored_reg, stored_next;
    logic [PW-1:0]     rlo_reg [MAX_NOTCHES];
    logic [PW-1:0]     rhi_reg [MAX_NOTCHES];

    // notch work registers
    logic signed [FREQ_W-1:0] lo_reg, hi_reg;
    logic [XW+PW-1:0]         prod_reg;
    logic [1:0]               cls_reg;
    logic signed [SW-1:0]     ibot_reg, itop_reg;
    logic [PW-1:0]            first_reg, last_reg, count_reg;

    // output register
    logic                  m_valid_reg;
    logic [SMP_W-1:0]      ore_reg, ore_next;
    logic [SMP_W-1:0]      oim_reg, oim_next;
    logic                  onotch_reg, onotch_next;
    logic [FRAC_W-1:0]     ofrac_reg, ofrac_next;
    logic [REM_W-1:0]      orem_reg, orem_next;
    status_t               ostat_reg, ostat_next;

    logic [PW-1:0]        p_eff, q_val;
    logic [BW_W-1:0]      bw_eff;
    logic                 full;
    logic                 out_load;
    logic signed [FREQ_W+1:0] f_x, chan_x, bw_x, lb_x, ub_x, x_x;
    logic [1:0]           cls_now;
    logic [WW-1:0]        div_num, div_den;
    logic [DIV_STEPS-1:0] quo;
    logic signed [SW-1:0] edge_val, p_s, first_s, last_s;
    logic [PW-1:0]        first_c, last_c, count_c;
    logic                 hit;
    logic [DIV_STEPS-1:0] nib;

    assign act     = action_t'(s_tuser);
    assign in_lo   = $signed(s_tdata[39:0]);
    assign in_hi   = $signed(s_tdata[79:40]);
    assign in_frac = s_tdata[95:80];
    assign in_idx  = s_tdata[107:96];
    assign in_re   = s_tdata[139:108];
    assign in_im   = s_tdata[171:140];

    always_comb begin
        if (points_reg < PTS_W'(4)) begin
            p_eff = PW'(4);
        end else if (32'(points_reg) > 32'(MAX_POINTS)) begin
            p_eff = PW'(MAX_POINTS);
        end else begin
            p_eff = PW'(points_reg);
        end
    end
    assign q_val  = p_eff >> 2;
    assign bw_eff = (bw_reg == '0) ? BW_W'(1) : bw_reg;
    assign full   = 32'(stored_reg) >= 32'(MAX_NOTCHES);

    assign stat.out_free   = !m_valid_reg || m_tready;
    assign stat.needs_calc = (act == ACT_NOTCH) && (in_hi > in_lo) && !full;

    // frequency to distance from the channel edge
    always_comb begin
        f_x    = (cmd.second ^ sideband_reg) ? {{2{hi_reg[FREQ_W-1]}}, hi_reg}
                                             : {{2{lo_reg[FREQ_W-1]}}, lo_reg};
        chan_x = {{2{chan_reg[FREQ_W-1]}}, chan_reg};
        bw_x   = $signed({3'b000, bw_eff});
        lb_x   = sideband_reg ? chan_x - bw_x : chan_x;
        ub_x   = sideband_reg ? chan_x : chan_x + bw_x;
        x_x    = sideband_reg ? ub_x - f_x : f_x - lb_x;
        if (f_x < lb_x) begin
            cls_now = sideband_reg ? CLS_HI : CLS_NEG;
        end else if (f_x < ub_x) begin
            cls_now = CLS_IN;
        end else begin
            cls_now = sideband_reg ? CLS_NEG : CLS_HI;
        end
    end

    always_comb begin
        if (cmd.div_load_nib) begin
            div_num = WW'({count_reg, 16'b0}) + WW'(q_val);
            div_den = WW'({q_val, 1'b0});
        end else begin
            div_num = WW'({prod_reg, 1'b0}) + WW'({bw_eff, 2'b00});
            div_den = WW'({bw_eff, 3'b000});
        end
    end

    snm_div #(.WW(WW), .QW(DIV_STEPS)) u_div (
        .aclk (aclk),
        .load (cmd.div_load_edge || cmd.div_load_nib),
        .num  (div_num),
        .den  (div_den),
        .step (cmd.div_step),
        .quo  (quo)
    );

    assign p_s = $signed({2'b00, p_eff});

    always_comb begin
        case (cls_reg)
            CLS_IN:  edge_val = $signed({2'b00, quo[PW-1:0]});
            CLS_NEG: edge_val = -SW'(1);
            default: edge_val = p_s + SW'(1);
        endcase
    end

    // clip to the channel and count
    always_comb begin
        first_s = ibot_reg + SW'(1);
        if (first_s < 0) first_s = '0;
        last_s = (itop_reg > p_s) ? p_s : itop_reg;
        if (last_s > first_s) begin
            first_c = first_s[PW-1:0];
            last_c  = last_s[PW-1:0];
            count_c = last_s[PW-1:0] - first_s[PW-1:0];
        end else begin
            first_c = '0;
            last_c  = '0;
            count_c = '0;
        end
    end

    always_comb begin
        hit = 1'b0;
        for (int i = 0; i < MAX_NOTCHES; i++) begin
            if ((32'(i) < 32'(stored_reg)) && (CW'(in_idx) >= CW'(rlo_reg[i]))
                    && (CW'(in_idx) < CW'(rhi_reg[i]))) begin
                hit = 1'b1;
            end
        end
    end

    assign nib = quo;

    always_comb begin
        frac_next   = frac_reg;
        stored_next = stored_reg;
        ore_next    = '0;
        oim_next    = '0;
        onotch_next = 1'b0;
        orem_next   = '0;
        ostat_next  = ST_OK;
        out_load    = 1'b0;
        if (cmd.finish) begin
            out_load    = 1'b1;
            stored_next = stored_reg + NCW'(1);
            if (nib != '0 && nib < DIV_STEPS'(frac_reg)) begin
                frac_next = frac_reg - nib[FRAC_W-1:0];
            end
            orem_next = REM_W'(count_reg);
        end else if (cmd.accept && !stat.needs_calc) begin
            case (act)
                ACT_BEGIN: begin
                    out_load    = 1'b1;
                    frac_next   = in_frac;
                    stored_next = '0;
                end
                ACT_NOTCH: begin
                    out_load   = 1'b1;
                    ostat_next = (in_hi > in_lo) ? ST_FULL : ST_ILLEGAL;
                end
                ACT_BIN: begin
                    out_load    = 1'b1;
                    onotch_next = hit;
                    if (!hit) begin
                        ore_next = in_re;
                        oim_next = in_im;
                    end
                end
                default: out_load = 1'b0;
            endcase
        end
        ofrac_next = frac_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sideband_reg <= 1'b0;
            chan_reg     <= '0;
            bw_reg       <= BW_W'(1048576);
            points_reg   <= PTS_W'(4096);
            frac_reg     <= '0;
            stored_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_SIDEBAND:  sideband_reg <= cfg_data[0];
                    REG_CHAN_FREQ: chan_reg     <= $signed(cfg_data);
                    REG_BANDWIDTH: bw_reg       <= cfg_data[BW_W-1:0];
                    REG_POINTS:    points_reg   <= cfg_data[PTS_W-1:0];
                    default:       sideband_reg <= sideband_reg;
                endcase
            end
            frac_reg   <= frac_next;
            stored_reg <= stored_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            lo_reg <= in_lo;
            hi_reg <= in_hi;
        end
        if (cmd.mul) begin
            prod_reg <= x_x[XW-1:0] * p_eff;
            cls_reg  <= cls_now;
        end
        if (cmd.save_edge) begin
            if (cmd.second) itop_reg <= edge_val;
            else            ibot_reg <= edge_val;
        end
        if (cmd.count) begin
            first_reg <= first_c;
            last_reg  <= last_c;
            count_reg <= count_c;
        end
        if (cmd.finish) begin
            rlo_reg[stored_reg[IW-1:0]] <= first_reg;
            rhi_reg[stored_reg[IW-1:0]] <= last_reg;
        end
        if (out_load) begin
            ore_reg    <= ore_next;
            oim_reg    <= oim_next;
            onotch_reg <= onotch_next;
            ofrac_reg  <= ofrac_next;
            orem_reg   <= orem_next;
            ostat_reg  <= ostat_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, orem_reg, ofrac_reg, oim_reg, ore_reg};
    assign m_tuser  = {ostat_reg, onotch_reg};

endmodule
`default_nettype wire

FILE: sv/snm_ctrl.sv
`default_nettype none
module snm_ctrl
    import snm_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    ctrl_state_t       state_reg, state_next;
    logic              second_reg, second_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            second_reg <= 1'b0;
            step_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            second_reg <= second_next;
            step_reg   <= step_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        second_next = second_reg;
        step_next   = step_reg;
        s_tready    = 1'b0;
        cmd         = '0;
        cmd.second  = second_reg;
        case (state_reg)
            S_IDLE: begin
                s_tready   = stat.out_free;
                cmd.accept = s_tvalid && stat.out_free;
                if (cmd.accept && stat.needs_calc) begin
                    second_next = 1'b0;
                    state_next  = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_ELOAD;
            end
            S_ELOAD: begin
                cmd.div_load_edge = 1'b1;
                step_next         = '0;
                state_next        = S_EDIV;
            end
            S_EDIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1)) state_next = S_ESAVE;
            end
            S_ESAVE: begin
                cmd.save_edge = 1'b1;
                if (second_reg) begin
                    state_next = S_COUNT;
                end else begin
                    second_next = 1'b1;
                    state_next  = S_MUL;
                end
            end
            S_COUNT: begin
                cmd.count  = 1'b1;
                state_next = S_NLOAD;
            end
            S_NLOAD: begin
                cmd.div_load_nib = 1'b1;
                step_next        = '0;
                state_next       = S_NDIV;
            end
            S_NDIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1)) state_next = S_FINISH;
            end
            S_FINISH: begin
                // hold until the output register can take the result
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

FILE: sv/spectral_notch_masker_top.sv
// Spectral notch masker for one channel's cross-power spectrum.
// Input beats on s_*: tuser carries the action (begin, notch, bin), tdata
// the notch edges, start fraction, bin index and bin value. Every begin,
// notch and bin beat yields one result beat on m_*; action three yields none.
// Configuration (sideband, channel edge, bandwidth, points) is written on
// cfg_* one register per beat, always ready; write it only while no item
// is in flight (not enforced). Bin and begin beats are not divided: the
// result is registered on acceptance and a new beat is taken every cycle
// while m_tready holds. A legal notch beat that fits the table runs both
// edge mappings and the fraction step on one shared restoring divider,
// with s_tready low from acceptance until the result is registered.
// Illegal notches and table-full notches return at once with their status.
// When the receiver stalls, the result holds in the output register and
// s_tready drops once that register is occupied and not draining.
// Reset (aresetn low, synchronous) loads register defaults, empties the
// notch table, zeroes the fraction and drops any pending result.
`default_nettype none
module spectral_notch_masker_top
    import snm_pkg::*;
#(
    parameter int MAX_POINTS  = DEF_MAX_POINTS,
    parameter int MAX_NOTCHES = DEF_MAX_NOTCHES
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // lo_freq, hi_freq, start_fraction, bin_index, bin_re, bin_im, zero pad
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // action
    input  wire logic [1:0]            s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // out_re, out_im, fraction, bins_removed, zero pad
    output logic      [OUT_DATA_W-1:0] m_tdata,
    // notched, status
    output logic      [OUT_USER_W-1:0] m_tuser
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    snm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    snm_dp #(.MAX_POINTS(MAX_POINTS), .MAX_NOTCHES(MAX_NOTCHES)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
`default_nettype wire

FILE: tb/sv/spectral_notch_masker_checker.sv
`timescale 1ns / 100ps
module spectral_notch_masker_checker
    import snm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic [1:0]            s_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata,
    input  wire logic [OUT_USER_W-1:0] m_tuser,
    output int                         pending,
    output int                         errors
);

    typedef struct {
        logic [SMP_W-1:0]  re;
        logic [SMP_W-1:0]  im;
        logic              notched;
        logic [FRAC_W-1:0] fraction;
        logic [REM_W-1:0]  removed;
        status_t           status;
    } masked_bin_t;

    masked_bin_t expected_bins[$];

    // shadow of the block's registers and notch table
    logic                     lower_sb;
    longint                   chan_edge;
    longint unsigned          chan_bw;
    int unsigned              chan_points;
    int unsigned              notch_lo[DEF_MAX_NOTCHES];
    int unsigned              notch_hi[DEF_MAX_NOTCHES];
    int unsigned              notch_count;
    logic [FRAC_W-1:0]        usable;

    function automatic longint edge_index(longint unsigned x, longint unsigned bw,
                                          longint unsigned p);
        return longint'((2 * x * p + 4 * bw) / (8 * bw));
    endfunction

    function automatic longint freq_to_index(longint f, longint unsigned bw,
                                             longint unsigned p);
        longint above;
        longint bottom;
        longint top;
        above = longint'(p) + 1;
        if (!lower_sb) begin
            bottom = chan_edge;
            top = bottom + longint'(bw);
            if (f < bottom) return -1;
            if (f < top) return edge_index(f - bottom, bw, p);
            return above;
        end
        top = chan_edge;
        bottom = top - longint'(bw);
        if (f < bottom) return above;
        if (f < top) return edge_index(top - f, bw, p);
        return -1;
    endfunction

    function automatic masked_bin_t mask_item(action_t act, logic [IN_DATA_W-1:0] d);
        masked_bin_t r;
        longint lo;
        longint hi;
        longint unsigned p;
        longint unsigned bw;
        longint ibot;
        longint itop;
        longint first;
        longint last;
        longint unsigned cnt;
        longint unsigned nib;
        int unsigned idx;
        r = '{re: '0, im: '0, notched: 1'b0, fraction: '0, removed: '0, status: ST_OK};
        case (act)
            ACT_BEGIN: begin
                usable = d[95:80];
                notch_count = 0;
            end
            ACT_NOTCH: begin
                lo = longint'(signed'(d[39:0]));
                hi = longint'(signed'(d[79:40]));
                if (hi <= lo) begin
                    r.status = ST_ILLEGAL;
                end else if (notch_count >= DEF_MAX_NOTCHES) begin
                    r.status = ST_FULL;
                end else begin
                    p = chan_points < 4 ? 4 : (chan_points > DEF_MAX_POINTS ?
                        DEF_MAX_POINTS : chan_points);
                    bw = chan_bw == 0 ? 1 : chan_bw;
                    ibot = freq_to_index(lower_sb ? hi : lo, bw, p);
                    itop = freq_to_index(lower_sb ? lo : hi, bw, p);
                    first = ibot + 1;
                    last = itop;
                    cnt = 0;
                    if (first < 0) first = 0;
                    if (last > longint'(p)) last = longint'(p);
                    if (last > first) cnt = longint'(last - first);
                    else begin
                        first = 0;
                        last = 0;
                    end
                    notch_lo[notch_count] = first;
                    notch_hi[notch_count] = last;
                    notch_count++;
                    r.removed = cnt;
                    if (cnt > 0) begin
                        nib = (cnt * 65536 + (p >> 2)) / (2 * (p >> 2));
                        if (nib > 0 && nib < usable) usable = usable - nib;
                    end
                end
            end
            default: begin
                idx = d[107:96];
                for (int i = 0; i < notch_count; i++)
                    if (idx >= notch_lo[i] && idx < notch_hi[i]) r.notched = 1'b1;
                if (!r.notched) begin
                    r.re = d[139:108];
                    r.im = d[171:140];
                end
            end
        endcase
        r.fraction = usable;
        return r;
    endfunction

    task automatic report(string field, longint unsigned want, longint unsigned got);
        $display("%0t: %s expected %0h got %0h", $realtime, field, want, got);
        errors++;
    endtask

    initial errors = 0;

    always @(posedge aclk) begin
        masked_bin_t w;
        if (!aresetn) begin
            lower_sb = 1'b0;
            chan_edge = 0;
            chan_bw = 1048576;
            chan_points = 4096;
            notch_count = 0;
            usable = '0;
            expected_bins.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SIDEBAND:  lower_sb = cfg_data[0];
                    REG_CHAN_FREQ: chan_edge = longint'(signed'(cfg_data));
                    REG_BANDWIDTH: chan_bw = cfg_data[BW_W-1:0];
                    REG_POINTS:    chan_points = cfg_data[PTS_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_bins.size() == 0) begin
                    report("unexpected beat", 0, m_tdata[63:0]);
                end else begin
                    w = expected_bins.pop_front();
                    if (m_tdata[31:0] !== w.re) report("out_re", w.re, m_tdata[31:0]);
                    if (m_tdata[63:32] !== w.im) report("out_im", w.im, m_tdata[63:32]);
                    if (m_tdata[79:64] !== w.fraction)
                        report("fraction", w.fraction, m_tdata[79:64]);
                    if (m_tdata[92:80] !== w.removed)
                        report("bins_removed", w.removed, m_tdata[92:80]);
                    if (m_tuser[0] !== w.notched) report("notched", w.notched, m_tuser[0]);
                    if (m_tuser[2:1] !== w.status) report("status", w.status, m_tuser[2:1]);
                end
            end
            // action three yields no beat
            if (s_tvalid && s_tready && action_t'(s_tuser) != ACT_NONE)
                expected_bins.push_back(mask_item(action_t'(s_tuser), s_tdata));
        end
        pending = expected_bins.size();
    end

endmodule

FILE: tb/sv/spectral_notch_masker_top_test.sv
`timescale 1ns / 100ps
module spectral_notch_masker_top_test;
    import snm_pkg::*;

    localparam longint FMIN = -(64'sd1 <<< 39);
    localparam longint FMAX = (64'sd1 <<< 39) - 1;
    localparam int CYCLE_LIMIT = 600000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    int                    pending;
    int                    errors;
    int                    cycles = 0;
    int                    stall_left = 0;
    logic                  calm = 1'b0;

    // current mapping, kept here to aim notches and bins at the channel
    longint                cur_edge = 0;
    longint                cur_bw = 1048576;
    int                    cur_points = 4096;

    always #2 aclk = ~aclk;

    spectral_notch_masker_top dut (.*);

    spectral_notch_masker_checker chk (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("spectral_notch_masker_top: mismatch");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            stall_left <= gap_len();
            m_tready <= 1'b1;
        end
    end

    function automatic longint clamp40(longint f);
        return f < FMIN ? FMIN : (f > FMAX ? FMAX : f);
    endfunction

    // valid stays high after the accepting edge; the next call replaces the beat or drops valid, drain drops it
    task automatic put_item(action_t act, longint lo, longint hi, logic [15:0] frac,
                            logic [11:0] idx, logic [31:0] re, logic [31:0] im);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {4'b0, im, re, idx, frac, hi[39:0], lo[39:0]};
        forever begin
            @(negedge aclk);
            if (s_tready) break;
        end
        @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint value);
        int gap;
        gap = $urandom_range(0, 2);
        if (gap > 0) begin
            cfg_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[39:0];
        forever begin
            @(negedge aclk);
            if (cfg_ready) break;
        end
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        // a dividing notch is already counted in pending; this wait is a margin
        repeat (80) @(posedge aclk);
    endtask

    task automatic set_channel(logic sb, longint edge_f, longint bw, int pts);
        drain();
        write_reg(REG_SIDEBAND, sb);
        write_reg(REG_CHAN_FREQ, edge_f);
        write_reg(REG_BANDWIDTH, bw);
        write_reg(REG_POINTS, pts);
        cfg_valid <= 1'b0;
        cur_edge = edge_f;
        cur_bw = bw == 0 ? 1 : bw;
        cur_points = pts < 4 ? 4 : (pts > 4096 ? 4096 : pts);
    endtask

    function automatic longint near_channel();
        if ($urandom_range(0, 19) == 0) return clamp40({$urandom, $urandom});
        return clamp40(cur_edge + cur_bw * $signed($urandom_range(0, 2600)) / 1024
                       - cur_bw * 1300 / 1024);
    endfunction

    task automatic random_run(int n);
        longint lo;
        longint hi;
        int r;
        logic [15:0] frac;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (k == 0 || r < 3) begin
                r = $urandom_range(0, 9);
                frac = r == 0 ? 16'h0 : (r == 1 ? 16'hFFFF : $urandom);
                put_item(ACT_BEGIN, $urandom, $urandom, frac, $urandom, $urandom, $urandom);
            end else if (r < 18) begin
                lo = near_channel();
                hi = $urandom_range(0, 9) == 0 ? lo - $urandom_range(0, 100)
                     : clamp40(lo + cur_bw * $urandom_range(1, 300) / 1024 + 1);
                put_item(ACT_NOTCH, lo, hi, $urandom, $urandom, $urandom, $urandom);
            end else if (r < 20) begin
                put_item(ACT_NONE, {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                         $urandom, $urandom, $urandom);
            end else begin
                put_item(ACT_BIN, {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                         $urandom_range(0, 9) == 0 ? $urandom_range(0, 4095)
                         : $urandom_range(0, cur_points - 1), $urandom, $urandom);
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: default channel, 0..16 MHz upper sideband, 4096 points
        put_item(ACT_BEGIN, 0, 0, 16'hFFFF, 0, 0, 0);
        put_item(ACT_NOTCH, FMIN, FMAX, 0, 0, 0, 0);
        put_item(ACT_BIN, 0, 0, 0, 12'd0, 32'h7FFFFFFF, 32'h80000000);
        put_item(ACT_BEGIN, 0, 0, 16'h8000, 0, 0, 0);
        put_item(ACT_NOTCH, 5 <<< 16, 5 <<< 16, 0, 0, 0, 0);
        put_item(ACT_NOTCH, 6 <<< 16, 5 <<< 16, 0, 0, 0, 0);
        put_item(ACT_NOTCH, -(1 <<< 16), 0, 0, 0, 0, 0);
        put_item(ACT_NOTCH, 16 <<< 16, 20 <<< 16, 0, 0, 0, 0);
        for (int i = 0; i < 7; i++)
            put_item(ACT_NOTCH, (2 * i) <<< 16, (2 * i + 1) <<< 16, 0, 0, 0, 0);
        put_item(ACT_NOTCH, 1, 2, 0, 0, 0, 0);
        put_item(ACT_BIN, 0, 0, 0, 12'd256, 32'h1, 32'hFFFFFFFF);
        put_item(ACT_BIN, 0, 0, 0, 12'd4095, 32'hFFFFFFFF, 32'h0);
        put_item(ACT_BIN, 0, 0, 0, 12'd300, 32'h80000000, 32'h7FFFFFFF);
        put_item(ACT_NONE, FMAX, FMIN, 16'hFFFF, 12'hFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        put_item(ACT_BEGIN, 0, 0, 16'h0, 0, 0, 0);
        put_item(ACT_NOTCH, 1 <<< 16, 3 <<< 16, 0, 0, 0, 0);
        put_item(ACT_BIN, 0, 0, 0, 12'd300, 32'h12345678, 32'h9ABCDEF0);

        calm = 1'b1;
        random_run(30);
        calm = 1'b0;

        set_channel(1'b0, 1000 <<< 16, 64 <<< 16, 256);
        random_run(40);
        // hold off until the block has emptied
        drain();
        random_run(30);
        set_channel(1'b1, 2000 <<< 16, 32 <<< 16, 4096);
        random_run(70);
        set_channel(1'b0, FMIN, FMAX, 8191);
        random_run(60);
        set_channel(1'b1, FMAX, 1, 4);
        random_run(50);
        set_channel(1'b0, $signed({$urandom, $urandom}) >>> 24, 0, 0);
        random_run(50);
        set_channel(1'b1, $signed({$urandom, $urandom}) >>> 26,
                    {$urandom_range(1, 255), $urandom_range(0, 65535)},
                    $urandom_range(4, 4096));
        random_run(70);
        set_channel(1'b0, -(500 <<< 16), 16 <<< 16, 64);
        random_run(60);
        set_channel(1'b1, 0, 12 <<< 16, 1024);
        random_run(60);

        drain();
        if (errors == 0)
            $display("spectral_notch_masker_top: match");
        else
            $display("spectral_notch_masker_top: mismatch");
        $finish;
    end

endmodule
